@@ rtl/assert_macros.svh @@
// Assertion helpers for the keyed list table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed_list_table: check failed");

// next-cycle implication
`define KLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed_list_table: check failed");

`endif

@@ rtl/klt_pkg.sv @@
`timescale 1ns / 1ps
package klt_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int FUNC_W      = 2;
  localparam int STAT_W      = 2;
  localparam int ENTRY_W     = 5;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

  // contents one cell hands to a neighbor
  typedef struct packed {
    logic                   valid;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } klt_link_t;

  // broadcast to every cell
  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic [KEY_WIDTH-1:0] key;
  } klt_bcast_t;

endpackage

@@ rtl/klt_in_if.sv @@
`timescale 1ns / 1ps
interface klt_in_if;
  import klt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [FUNC_W-1:0]  func;
  logic signed [FIELD_W-1:0] key;
  logic signed [FIELD_W-1:0] value_in;

  modport source (output valid, output func, output key, output value_in, input ready);
  modport sink (input valid, input func, input key, input value_in, output ready);
endinterface

@@ rtl/klt_out_if.sv @@
`timescale 1ns / 1ps
interface klt_out_if;
  import klt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [STAT_W-1:0]  status;
  logic signed [FIELD_W-1:0] value_out;
  logic        [ENTRY_W-1:0] entry_count;

  modport source (output valid, output status, output value_out, output entry_count,
                  input ready);
  modport sink (input valid, input status, input value_out, input entry_count,
                output ready);
endinterface

@@ rtl/klt_cell.sv @@
`timescale 1ns / 1ps
module klt_cell
  import klt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  klt_bcast_t             bc,
  input  klt_link_t              left_in,
  input  klt_link_t              right_in,
  input  logic                   found_in,
  input  logic [VALUE_WIDTH-1:0] sel_in,
  output klt_link_t              cur,
  output logic                   found_out,
  output logic [VALUE_WIDTH-1:0] sel_out
);

  logic valid;
  logic [KEY_WIDTH-1:0] key;
  logic [VALUE_WIDTH-1:0] value;
  logic match;
  logic pull_right;

  assign match      = valid && (key == bc.key);
  assign found_out  = found_in || match;
  assign sel_out    = (match && !found_in) ? value : sel_in;
  assign pull_right = bc.rem && found_out;
  assign cur        = '{valid: valid, key: key, value: value};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (bc.ins) begin
      valid <= left_in.valid;
    end else if (pull_right) begin
      valid <= right_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bc.ins) begin
      key   <= left_in.key;
      value <= left_in.value;
    end else if (pull_right) begin
      key   <= right_in.key;
      value <= right_in.value;
    end
  end

endmodule

@@ rtl/keyed_list_table.sv @@
`timescale 1ns / 1ps
// Keyed list table: up to DEPTH key/data entries kept newest first in a row of cells.
// Insert pushes a word in at the front (status full when all cells are used, duplicates
// allowed), lookup returns the data of the newest matching key, remove drops the newest
// match and the older entries slide up one cell. A word is captured, then the key
// compare and match ripple through the cells and the update happen at commit.
// A new word is taken once the previous one has committed; commit waits while the
// result register still holds an unread word.
module keyed_list_table
  import klt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  klt_in_if.sink    req,
  klt_out_if.source rsp
);
  `include "assert_macros.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                   state;
  logic [FUNC_W-1:0]      op;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [STAT_W-1:0]      status_next;
  logic                   rsp_valid;
  logic [STAT_W-1:0]      rsp_status;
  logic [FIELD_W-1:0]     rsp_value;
  logic [ENTRY_W-1:0]     rsp_count;

  logic       commit;
  logic       hit;
  klt_bcast_t bc;

  klt_link_t              cur      [DEPTH];
  klt_link_t              link_l   [DEPTH];
  klt_link_t              link_r   [DEPTH];
  logic                   found    [DEPTH+1];
  logic [VALUE_WIDTH-1:0] sel      [DEPTH+1];
  logic [DEPTH-1:0]       valid_vec;

  assign req.ready = (state == S_IDLE);
  assign commit    = (state == S_EXEC) && (!rsp_valid || rsp.ready);
  assign hit       = found[DEPTH];

  assign bc.key = key_r;
  assign bc.ins = commit && (op == FN_INSERT) && (count != FULL_COUNT);
  assign bc.rem = commit && (op == FN_REMOVE) && hit;

  assign found[0] = 1'b0;
  assign sel[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign link_l[i] = '{valid: 1'b1, key: key_r, value: value_r};
    end else begin : g_mid
      assign link_l[i] = cur[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign link_r[i] = '{valid: 1'b0, key: '0, value: '0};
    end else begin : g_body
      assign link_r[i] = cur[i+1];
    end
    assign valid_vec[i] = cur[i].valid;

    klt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .bc        (bc),
      .left_in   (link_l[i]),
      .right_in  (link_r[i]),
      .found_in  (found[i]),
      .sel_in    (sel[i]),
      .cur       (cur[i]),
      .found_out (found[i+1]),
      .sel_out   (sel[i+1])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = STAT_OK;
    case (op)
      FN_INSERT: begin
        if (count == FULL_COUNT) begin
          status_next = STAT_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      FN_LOOKUP: begin
        if (!hit) begin
          status_next = STAT_MISS;
        end
      end
      FN_REMOVE: begin
        if (!hit) begin
          status_next = STAT_MISS;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op      <= req.func;
      key_r   <= req.key[KEY_WIDTH-1:0];
      value_r <= req.value_in[VALUE_WIDTH-1:0];
    end
    if (commit) begin
      rsp_status <= status_next;
      rsp_value  <= ((op == FN_LOOKUP) && hit) ? FIELD_W'(sel[DEPTH]) : '0;
      rsp_count  <= ENTRY_W'(count_next);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.value_out   = rsp_value;
  assign rsp.entry_count = rsp_count;

  `KLT_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL_COUNT)
  `KLT_ASSERT_NOW(a_valid_packed, 1'b1, $countones(valid_vec) == count)
  `KLT_ASSERT_NEXT(a_full_reject, commit && (op == FN_INSERT) && (count == FULL_COUNT),
                   (rsp.status == STAT_FULL) && (count == FULL_COUNT))
  `KLT_ASSERT_NEXT(a_remove_shrinks, bc.rem, count == $past(count) - CNT_W'(1))

endmodule
